// File: sv/bmf_pkg.sv
`default_nettype none
package bmf_pkg;

    localparam int DIM_W = 12;
    localparam int PIX_W = 24;
    localparam int POS_W = 11;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_HALF   = 3;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;
    localparam logic [1:0]       RST_HALF_W = 2'd2;
    localparam logic [1:0]       RST_HALF_H = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HALF_W = 2'd2;
    localparam logic [1:0] REG_HALF_H = 2'd3;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } req_t;

    typedef struct packed {
        logic [7:0]       avg0;
        logic [7:0]       avg1;
        logic [7:0]       avg2;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } res_t;

    typedef struct packed {
        logic row_load;
        logic q_load;
        logic slot_load;
        logic acc_en;
    } lane_ctrl_t;

    // reflect-101 about the edges, then clamp for tiny images
    function automatic logic [DIM_W-1:0] mirror(input logic signed [15:0] x,
                                                input logic [DIM_W-1:0] n);
        logic signed [15:0] v;
        logic signed [15:0] top;
        top = $signed(16'(n)) - 16'sd1;
        v = x;
        if (v < 16'sd0) v = -v;
        if (v > top) v = 16'sd2 * top - v;
        if (v < 16'sd0) v = 16'sd0;
        if (v > top) v = top;
        return DIM_W'(v);
    endfunction

endpackage
`default_nettype wire

// File: sv/bmf_ram.sv
`default_nettype none
module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: sv/bmf_lane.sv
`default_nettype none
module bmf_lane #(
    parameter int MAX_HALF = 3,
    parameter int IDX      = 0
) (
    input  wire logic                                           clk,
    input  wire bmf_pkg::lane_ctrl_t                            ctrl,
    input  wire logic [bmf_pkg::DIM_W-1:0]                      emit_row,
    input  wire logic [bmf_pkg::DIM_W-1:0]                      height,
    input  wire logic [$clog2(MAX_HALF+1)-1:0]                  half_h,
    input  wire logic [2*MAX_HALF:0][bmf_pkg::PIX_W-1:0]        rd_data,
    output logic [2:0][$clog2((2*MAX_HALF+1)*255+1)-1:0]        sums
);
    import bmf_pkg::*;

    localparam int RING = 2 * MAX_HALF + 1;
    localparam int SLW  = $clog2(RING);
    localparam int LSW  = $clog2(RING * 255 + 1);
    localparam int KR   = DIM_W + 5;
    localparam int RC   = ((1 << KR) + RING - 1) / RING;

    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] q_reg;
    logic [SLW-1:0]   slot_reg;
    logic             active_reg;
    logic signed [15:0] row_pos;
    logic [DIM_W-1:0] rem;
    logic [PIX_W-1:0] pix;

    assign row_pos = $signed(16'(emit_row)) + 16'(IDX) - $signed(16'(half_h));
    assign rem     = row_reg - DIM_W'(32'(q_reg) * RING);
    assign pix     = rd_data[slot_reg];

    always_ff @(posedge clk)
    begin
        if (ctrl.row_load)
        begin
            row_reg    <= mirror(row_pos, height);
            active_reg <= (32'(IDX) <= 2 * 32'(half_h));
        end
        if (ctrl.q_load)
        begin
            q_reg <= DIM_W'((32'(row_reg) * RC) >> KR);
        end
        if (ctrl.slot_load)
        begin
            slot_reg <= SLW'(rem);
        end
        for (int c = 0; c < 3; c++)
        begin
            if (ctrl.slot_load)
            begin
                sums[c] <= '0;
            end
            else if (ctrl.acc_en && active_reg)
            begin
                sums[c] <= sums[c] + LSW'(pix[8*c +: 8]);
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/bmf_merge.sv
`default_nettype none
module bmf_merge #(
    parameter int MAX_HALF = 3
) (
    input  wire logic                                                 clk,
    input  wire logic [2*MAX_HALF:0][2:0][$clog2((2*MAX_HALF+1)*255+1)-1:0] lane_sums,
    input  wire logic [$clog2(MAX_HALF+1)-1:0]                        half_h,
    input  wire logic [$clog2(MAX_HALF+1)-1:0]                        half_w,
    output logic [2:0][7:0]                                           avg
);
    localparam int LANES = 2 * MAX_HALF + 1;
    localparam int AMAX  = LANES * LANES;
    localparam int SW    = $clog2(AMAX * 255 + 1);
    localparam int K     = SW + $clog2(AMAX) + 1;
    localparam int MW    = K + 1;

    logic [MAX_HALF:0][MAX_HALF:0][MW-1:0] recip_tab;
    logic [2:0][SW-1:0]    tot;
    logic [2:0][SW-1:0]    tot_reg;
    logic [MW-1:0]         recip_reg;
    logic [2:0][SW+MW-1:0] prod_reg;

    for (genvar i = 0; i <= MAX_HALF; i++)
    begin : g_rh
        for (genvar j = 0; j <= MAX_HALF; j++)
        begin : g_rw
            localparam longint AREA = (2 * i + 1) * (2 * j + 1);
            localparam longint RCP  = ((64'd1 << K) + AREA - 1) / AREA;
            assign recip_tab[i][j] = MW'(RCP);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tot[c] = '0;
            for (int k = 0; k < LANES; k++)
            begin
                tot[c] = tot[c] + SW'(lane_sums[k][c]);
            end
        end
    end

    // divide by the window area with a rounded-up reciprocal
    always_ff @(posedge clk)
    begin
        tot_reg   <= tot;
        recip_reg <= recip_tab[half_h][half_w];
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= (SW+MW)'(tot_reg[c]) * (SW+MW)'(recip_reg);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            avg[c] = prod_reg[c][K +: 8];
        end
    end
endmodule
`default_nettype wire

// File: sv/rgb_box_mean_filter.sv
`default_nettype none
// rgb box mean filter, reflect-101 border, raster order in and out
// req channel: one request per pixel (func push) or per drain (func drain);
//   valid/stall handshake, accepted when req_valid is high and req_stall low
// res channel: one result per completed window, valid/stall handshake, held
//   in an output register while res_stall is high
// config: apb-style, registers at 0x0 width, 0x4 height, 0x8 half width,
//   0xc half height; any write restarts the frame, line store is kept
// a push whose window completes nothing only writes the line store; a request
//   that emits a result runs setup states for the lane row and ring slot, reads
//   each window column in turn on the shared read port of the slot memories,
//   then accumulate, lane sum, reciprocal multiply and load
// results appear in raster order; after the last pixel of the frame the
//   pending rows are flushed by drain requests, one result each
// reset: counters and frame flag clear, registers take 640x480, 5x5 window;
//   the line store holds no data until written and needs no clearing pass
// a stalled receiver holds the output register; the next request is still
//   taken, and its result waits in the load state until the register frees
module rgb_box_mean_filter #(
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_HALF   = bmf_pkg::DEF_MAX_HALF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bmf_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_stall,
    output bmf_pkg::res_t      res,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bmf_pkg::*;

    localparam int RING = 2 * MAX_HALF + 1;
    localparam int SLW  = $clog2(RING);
    localparam int HW   = $clog2(MAX_HALF + 1);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int LSW  = $clog2(RING * 255 + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROW   = 4'd1;
    localparam logic [3:0] S_SLOT1 = 4'd2;
    localparam logic [3:0] S_SLOT2 = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_TAIL  = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [1:0]       half_w_reg, half_h_reg;
    logic [DIM_W-1:0] in_row_reg, in_row_next;
    logic [DIM_W-1:0] in_col_reg, in_col_next;
    logic [SLW-1:0]   in_slot_reg, in_slot_next;
    logic [DIM_W-1:0] emit_row_reg, emit_row_next;
    logic [DIM_W-1:0] emit_col_reg, emit_col_next;
    logic             done_reg, done_next;
    logic [SLW-1:0]   col_reg, col_next;
    logic             rd_valid_reg;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [HW-1:0]    hw_eff, hh_eff;
    logic             cfg_wr, accept, push, emit_start, load, last;
    logic [DIM_W-1:0] need_r, need_c;
    logic             win_ready;
    logic signed [15:0] col_pos;
    logic [AW-1:0]    rd_addr;
    logic [RING-1:0][PIX_W-1:0] rd_data;
    logic [RING-1:0][2:0][LSW-1:0] lane_sums;
    logic [2:0][7:0]  avg;
    lane_ctrl_t       lane_ctrl;

    // effective geometry
    always_comb
    begin
        if (width_reg == '0) w_eff = DIM_W'(1);
        else if (32'(width_reg) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
        else w_eff = width_reg;
        if (height_reg == '0) h_eff = DIM_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
        else h_eff = height_reg;
        hw_eff = (32'(half_w_reg) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_w_reg);
        hh_eff = (32'(half_h_reg) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_h_reg);
    end

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_HALF_W: prdata = 32'(half_w_reg);
            REG_HALF_H: prdata = 32'(half_h_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            half_w_reg <= RST_HALF_W;
            half_h_reg <= RST_HALF_H;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_HALF_W: half_w_reg <= pwdata[1:0];
                REG_HALF_H: half_h_reg <= pwdata[1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // request side
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign push      = accept && (req.func == FUNC_PUSH) && !done_reg;

    // window complete once the lower right pixel of it has arrived
    always_comb
    begin
        need_r = (32'(emit_row_reg) + 32'(hh_eff) > 32'(h_eff) - 1)
               ? h_eff - DIM_W'(1) : emit_row_reg + DIM_W'(hh_eff);
        need_c = (32'(emit_col_reg) + 32'(hw_eff) > 32'(w_eff) - 1)
               ? w_eff - DIM_W'(1) : emit_col_reg + DIM_W'(hw_eff);
        win_ready = (in_row_reg > need_r) || (in_row_reg == need_r && in_col_reg >= need_c);
    end

    assign emit_start = (push && win_ready)
                     || (accept && (req.func == FUNC_DRAIN) && done_reg);
    assign load = (state_reg == S_OUT) && (!res_valid_reg || !res_stall);
    assign last = (emit_row_reg == h_eff - DIM_W'(1)) && (emit_col_reg == w_eff - DIM_W'(1));

    // column walk for the shared read port
    assign col_pos = $signed(16'(emit_col_reg)) + $signed(16'(col_reg))
                   - $signed(16'(hw_eff));
    assign rd_addr = AW'(mirror(col_pos, w_eff));

    always_comb
    begin
        state_next    = state_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        done_next     = done_reg;
        col_next      = col_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (push)
        begin
            if (in_col_reg + DIM_W'(1) >= w_eff)
            begin
                in_col_next  = '0;
                in_slot_next = (32'(in_slot_reg) == RING - 1) ? '0 : in_slot_reg + SLW'(1);
                if (in_row_reg + DIM_W'(1) >= h_eff)
                begin
                    in_row_next  = '0;
                    in_slot_next = '0;
                    done_next    = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + DIM_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + DIM_W'(1);
            end
        end

        unique case (state_reg)
            S_IDLE:  if (emit_start) state_next = S_ROW;
            S_ROW:   state_next = S_SLOT1;
            S_SLOT1: state_next = S_SLOT2;
            S_SLOT2:
            begin
                state_next = S_READ;
                col_next   = '0;
            end
            S_READ:
            begin
                if (32'(col_reg) >= 2 * 32'(hw_eff)) state_next = S_TAIL;
                else col_next = col_reg + SLW'(1);
            end
            S_TAIL:  state_next = S_SUM;
            S_SUM:   state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:
            begin
                if (load)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    if (last)
                    begin
                        in_row_next   = '0;
                        in_col_next   = '0;
                        in_slot_next  = '0;
                        emit_row_next = '0;
                        emit_col_next = '0;
                        done_next     = 1'b0;
                    end
                    else if (emit_col_reg + DIM_W'(1) >= w_eff)
                    begin
                        emit_col_next = '0;
                        emit_row_next = emit_row_reg + DIM_W'(1);
                    end
                    else
                    begin
                        emit_col_next = emit_col_reg + DIM_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // any register write restarts the frame
        if (cfg_wr)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_slot_next  = '0;
            emit_row_next = '0;
            emit_col_next = '0;
            done_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            done_reg      <= 1'b0;
            col_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            in_slot_reg   <= in_slot_next;
            emit_row_reg  <= emit_row_next;
            emit_col_reg  <= emit_col_next;
            done_reg      <= done_next;
            col_reg       <= col_next;
            rd_valid_reg  <= (state_reg == S_READ);
            res_valid_reg <= res_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg.avg0       <= avg[0];
            res_reg.avg1       <= avg[1];
            res_reg.avg2       <= avg[2];
            res_reg.out_row    <= emit_row_reg[POS_W-1:0];
            res_reg.out_col    <= emit_col_reg[POS_W-1:0];
            res_reg.frame_last <= last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // one memory per ring slot, all read at the same column
    for (genvar s = 0; s < RING; s++)
    begin : g_slot
        bmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (push && (32'(in_slot_reg) == s)),
            .wr_addr (AW'(in_col_reg)),
            .wr_data ({req.chan2, req.chan1, req.chan0}),
            .rd_en   (state_reg == S_READ),
            .rd_addr (rd_addr),
            .rd_data (rd_data[s])
        );
    end

    assign lane_ctrl.row_load  = (state_reg == S_ROW);
    assign lane_ctrl.q_load    = (state_reg == S_SLOT1);
    assign lane_ctrl.slot_load = (state_reg == S_SLOT2);
    assign lane_ctrl.acc_en    = rd_valid_reg;

    // one lane per window row
    for (genvar k = 0; k < RING; k++)
    begin : g_lane
        bmf_lane #(
            .MAX_HALF (MAX_HALF),
            .IDX      (k)
        ) u_lane (
            .clk      (clk),
            .ctrl     (lane_ctrl),
            .emit_row (emit_row_reg),
            .height   (h_eff),
            .half_h   (hh_eff),
            .rd_data  (rd_data),
            .sums     (lane_sums[k])
        );
    end

    bmf_merge #(
        .MAX_HALF (MAX_HALF)
    ) u_merge (
        .clk       (clk),
        .lane_sums (lane_sums),
        .half_h    (hh_eff),
        .half_w    (hw_eff),
        .avg       (avg)
    );

    // no request taken while an item is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("request accepted while busy");

    // column walk stays inside the window
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (32'(col_reg) <= 2 * 32'(hw_eff)))
        else $error("column index past window");

    // a stalled full output register is never overwritten
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_valid_reg && res_stall) |=> (state_reg == S_OUT))
        else $error("result loaded over a stalled result");

    // write slot stays on the ring
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_slot_reg) < RING)
        else $error("ring slot out of range");

endmodule
`default_nettype wire
